// ----- design/bpra_pkg.sv -----
// ----------------------------------------------------------------------------
// bpra_pkg: shared types and constants of the bitmap page run allocator
// Item layouts, status and mode codes, register indexes and map geometry.
// ----------------------------------------------------------------------------
package bpra_pkg;

   localparam int ADDR_W          = 32;
   localparam int CNT_W           = 13;
   localparam int STATUS_W        = 2;
   localparam int PAGE_SHIFT      = 12;
   localparam int WORD_BITS       = 32;
   localparam int LANE_W          = 5;
   localparam int RUN_W           = CNT_W + 1;
   localparam int WIDX_W          = CNT_W - LANE_W;
   localparam int IDX_HI_W        = ADDR_W - PAGE_SHIFT;
   localparam int CNT_MAX         = (1 << CNT_W) - 1;

   localparam int NUM_PAGES_DEF   = 4096;
   localparam int MAP_WORDS_DEF   = (NUM_PAGES_DEF + WORD_BITS - 1) / WORD_BITS;

   localparam logic [CNT_W-1:0]  POOL_PAGES_RESET = CNT_W'(4096);
   localparam logic [ADDR_W-1:0] BASE_RESET       = '0;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

   // request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL = 2'd1;

   typedef struct packed {
      logic              mode;
      logic [CNT_W-1:0]  page_count;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   run_address;
   } rsp_type;

   // result of evaluating one map word against the running free count
   typedef struct packed {
      logic              hit;
      logic [LANE_W-1:0] pos;
      logic [CNT_W-1:0]  run_out;
   } scan_result_type;

endpackage

// ----- design/bitmap_page_run_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator_unit: first-fit page run allocator over a bitmap
// Steps: a bad request is flagged from the check state; an allocate scans
//   the map one word per cycle until a hit or the pool end, then reads and
//   writes back each map word the run spans; a free goes straight to that
//   read-modify-write of each map word it spans. One item at a time; the
//   next is taken from the result cycle.
// Reset: clears the map in one pass over all map words with busy high.
// The result is strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator_unit #(
   parameter int NUM_PAGES = bpra_pkg::NUM_PAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            start,
   output logic                            busy,
   input  bpra_pkg::req_type               req_item,
   // result
   output logic                            rsp_strobe,
   output bpra_pkg::rsp_type               rsp_item,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bpra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpra_pkg::ADDR_W-1:0]     csr_data
);

   localparam int NB        = bpra_pkg::WORD_BITS;
   localparam int LV        = bpra_pkg::LANE_W;
   localparam int CW        = bpra_pkg::CNT_W;
   localparam int AW_B      = bpra_pkg::ADDR_W;
   localparam int MAP_WORDS = (NUM_PAGES + NB - 1) / NB;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   // pool_pages is 13 bits, so the usable pool never exceeds its maximum
   localparam int POOL_CAP  = (NUM_PAGES < bpra_pkg::CNT_MAX) ? NUM_PAGES : bpra_pkg::CNT_MAX;
   localparam logic [NB-1:0] ALL_ONES = {NB{1'b1}};

   typedef enum logic [5:0] {
      S_CLEAR   = 6'b000001,
      S_IDLE    = 6'b000010,
      S_CHECK   = 6'b000100,
      S_SCAN    = 6'b001000,
      S_MARK_RD = 6'b010000,
      S_MARK_WR = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;

   // configuration
   logic [AW_B-1:0]               base_ff;
   logic [CW-1:0]                 pool_ff;

   // request held for the duration of the item
   logic                          mode_ff, mode_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW_B-1:0]               offset_ff, offset_in;

   // scan and mark bookkeeping
   logic [bpra_pkg::WIDX_W-1:0]   iss_ff, iss_in;
   logic                          iss_done_ff, iss_done_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic [bpra_pkg::WIDX_W-1:0]   dw_ff, dw_in;
   logic [CW-1:0]                 run_ff, run_in;
   logic [CW-1:0]                 lo_ff, lo_in;
   logic [CW-1:0]                 hi_last_ff, hi_last_in;
   logic [bpra_pkg::WIDX_W-1:0]   word_ff, word_in;
   logic [WORD_AW-1:0]            clr_ff, clr_in;

   // result
   logic                          rsp_strobe_ff, rsp_strobe_in;
   bpra_pkg::rsp_type             rsp_ff, rsp_in;

   // map port
   logic                          map_re;
   logic [WORD_AW-1:0]            map_raddr;
   logic [NB-1:0]                 map_rdata;
   logic                          map_we;
   logic [WORD_AW-1:0]            map_waddr;
   logic [NB-1:0]                 map_wdata;

   // scan unit
   logic [NB-1:0]                 scan_mask;
   bpra_pkg::scan_result_type     scan_res;

   // derived pool geometry
   logic [CW-1:0]                 pool_eff;
   logic [CW-1:0]                 pool_m1;
   logic [bpra_pkg::WIDX_W-1:0]   last_word;
   logic [NB-1:0]                 tail_mask;

   // request checks
   logic [bpra_pkg::IDX_HI_W-1:0] free_idx;
   logic                          count_bad;
   logic                          free_bad;
   logic [CW:0]                   free_end;
   logic [CW-1:0]                 hit_page;
   logic [NB-1:0]                 low_mask;
   logic [NB-1:0]                 high_mask;
   logic [NB-1:0]                 run_mask;
   logic                          accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // pool in effect is min(pool_pages, NUM_PAGES)
   assign pool_eff  = (pool_ff > CW'(POOL_CAP)) ? CW'(POOL_CAP) : pool_ff;
   assign pool_m1   = pool_eff - CW'(1);
   assign last_word = pool_m1[CW-1:LV];
   // pages past the pool end read as used
   assign tail_mask = (pool_eff[LV-1:0] == '0) ? ALL_ONES : ~(ALL_ONES << pool_eff[LV-1:0]);
   assign scan_mask = (dw_ff == last_word) ? tail_mask : ALL_ONES;

   assign free_idx  = offset_ff[AW_B-1:bpra_pkg::PAGE_SHIFT];
   assign free_end  = {1'b0, offset_ff[bpra_pkg::PAGE_SHIFT+CW-1:bpra_pkg::PAGE_SHIFT]}
                      + {1'b0, count_ff};
   assign count_bad = (count_ff == '0) || (count_ff > pool_eff);
   assign free_bad  = (offset_ff[bpra_pkg::PAGE_SHIFT-1:0] != '0)
                      || (free_idx >= bpra_pkg::IDX_HI_W'(pool_eff))
                      || (free_end > {1'b0, pool_eff});

   assign hit_page  = {dw_ff, scan_res.pos};

   // bits of the current map word that belong to the run [lo, hi_last]
   assign low_mask  = (word_ff == lo_ff[CW-1:LV]) ? (ALL_ONES << lo_ff[LV-1:0]) : ALL_ONES;
   assign high_mask = (word_ff == hi_last_ff[CW-1:LV])
                      ? (ALL_ONES >> (LV'(NB - 1) - hi_last_ff[LV-1:0])) : ALL_ONES;
   assign run_mask  = low_mask & high_mask;

   bpra_map_ram #(
      .WORDS  (MAP_WORDS),
      .AW     (WORD_AW)
   ) u_map (
      .clock   (clock),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata)
   );

   bpra_word_scan u_scan (
      .map_word   (map_rdata),
      .valid_mask (scan_mask),
      .run_in     (run_ff),
      .count      (count_ff),
      .result     (scan_res)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      offset_in     = offset_ff;
      iss_in        = iss_ff;
      iss_done_in   = iss_done_ff;
      rd_pend_in    = 1'b0;
      dw_in         = dw_ff;
      run_in        = run_ff;
      lo_in         = lo_ff;
      hi_last_in    = hi_last_ff;
      word_in       = word_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      map_re        = 1'b0;
      map_raddr     = WORD_AW'(word_ff);
      map_we        = 1'b0;
      map_waddr     = WORD_AW'(word_ff);
      map_wdata     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            clr_in    = clr_ff + WORD_AW'(1);
            if (clr_ff == WORD_AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               mode_in   = req_item.mode;
               count_in  = req_item.page_count;
               offset_in = req_item.address - base_ff;
               state_in  = S_CHECK;
            end
         end

         S_CHECK: begin
            if (count_bad || (mode_ff == bpra_pkg::MODE_FREE && free_bad)) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.status      = bpra_pkg::ST_BAD;
               rsp_in.run_address = '0;
               state_in           = S_IDLE;
            end else if (mode_ff == bpra_pkg::MODE_FREE) begin
               lo_in      = offset_ff[bpra_pkg::PAGE_SHIFT+CW-1:bpra_pkg::PAGE_SHIFT];
               hi_last_in = free_end[CW-1:0] - CW'(1);
               word_in    = offset_ff[bpra_pkg::PAGE_SHIFT+CW-1:bpra_pkg::PAGE_SHIFT+LV];
               state_in   = S_MARK_RD;
            end else begin
               iss_in      = '0;
               iss_done_in = 1'b0;
               run_in      = '0;
               state_in    = S_SCAN;
            end
         end

         S_SCAN: begin
            // stream one word per cycle out of the map
            if (!iss_done_ff) begin
               map_re      = 1'b1;
               map_raddr   = WORD_AW'(iss_ff);
               iss_in      = iss_ff + bpra_pkg::WIDX_W'(1);
               iss_done_in = (iss_ff == last_word);
               dw_in       = iss_ff;
               rd_pend_in  = 1'b1;
            end
            if (rd_pend_ff) begin
               if (scan_res.hit) begin
                  lo_in      = hit_page - count_ff + CW'(1);
                  hi_last_in = hit_page;
                  word_in    = lo_in[CW-1:LV];
                  rd_pend_in = 1'b0;
                  state_in   = S_MARK_RD;
               end else begin
                  run_in = scan_res.run_out;
                  if (dw_ff == last_word) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_in.status      = bpra_pkg::ST_NOSPACE;
                     rsp_in.run_address = '0;
                     rd_pend_in         = 1'b0;
                     state_in           = S_IDLE;
                  end
               end
            end
         end

         S_MARK_RD: begin
            map_re    = 1'b1;
            map_raddr = WORD_AW'(word_ff);
            state_in  = S_MARK_WR;
         end

         S_MARK_WR: begin
            map_we    = 1'b1;
            map_waddr = WORD_AW'(word_ff);
            map_wdata = (mode_ff == bpra_pkg::MODE_ALLOC) ? (map_rdata | run_mask)
                                                          : (map_rdata & ~run_mask);
            if (word_ff == hi_last_ff[CW-1:LV]) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = bpra_pkg::ST_DONE;
               rsp_in.run_address = (mode_ff == bpra_pkg::MODE_ALLOC)
                  ? base_ff + (AW_B'(lo_ff) << bpra_pkg::PAGE_SHIFT) : '0;
               state_in = S_IDLE;
            end else begin
               word_in  = word_ff + bpra_pkg::WIDX_W'(1);
               state_in = S_MARK_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         iss_done_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rd_pend_ff    <= rd_pend_in;
         iss_done_ff   <= iss_done_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      count_ff   <= count_in;
      offset_ff  <= offset_in;
      iss_ff     <= iss_in;
      dw_ff      <= dw_in;
      run_ff     <= run_in;
      lo_ff      <= lo_in;
      hi_last_ff <= hi_last_in;
      word_ff    <= word_in;
      rsp_ff     <= rsp_in;
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= bpra_pkg::BASE_RESET;
         pool_ff <= bpra_pkg::POOL_PAGES_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == bpra_pkg::CSR_BASE) begin
            base_ff <= csr_data;
         end else if (csr_index == bpra_pkg::CSR_POOL) begin
            pool_ff <= csr_data[CW-1:0];
         end
      end
   end

   // a result is a single-cycle pulse
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held past one cycle");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CHECK))
      else $error("accepted item did not enter check");

   a_map_write: assert property (@(posedge clock) disable iff (reset)
      map_we |-> (state_ff == S_CLEAR || state_ff == S_MARK_WR))
      else $error("map written outside clear or mark");

   a_run_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (run_ff < count_ff))
      else $error("running free count reached request without a hit");

   a_mark_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK_WR) |-> (word_ff <= hi_last_ff[CW-1:LV]))
      else $error("mark walked past the run end");

endmodule

// ----- design/bpra_map_ram.sv -----
// ----------------------------------------------------------------------------
// bpra_map_ram: page usage bitmap storage
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bpra_map_ram #(
   parameter int WORDS = bpra_pkg::MAP_WORDS_DEF,
   parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [AW-1:0]                  rd_addr,
   output logic [bpra_pkg::WORD_BITS-1:0] rd_data,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [bpra_pkg::WORD_BITS-1:0] wr_data
);

   logic [bpra_pkg::WORD_BITS-1:0] mem [WORDS];
   logic [bpra_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bpra_word_scan.sv -----
// ----------------------------------------------------------------------------
// bpra_word_scan: free run detector for one bitmap word
// Extends the running free count across 32 pages and flags the first page
// at which the run reaches the requested length.
// ----------------------------------------------------------------------------
module bpra_word_scan (
   input  logic [bpra_pkg::WORD_BITS-1:0] map_word,
   input  logic [bpra_pkg::WORD_BITS-1:0] valid_mask,
   input  logic [bpra_pkg::CNT_W-1:0]     run_in,
   input  logic [bpra_pkg::CNT_W-1:0]     count,
   output bpra_pkg::scan_result_type      result
);

   localparam int NB = bpra_pkg::WORD_BITS;
   localparam int LV = bpra_pkg::LANE_W;

   logic [LV:0]                    last_used [LV+1][NB];
   logic [bpra_pkg::RUN_W-1:0]     run_end   [NB];
   logic [NB-1:0]                  hit_vec;
   logic [NB-1:0]                  used;

   // prefix max of (used ? position+1 : 0), log-depth
   always_comb begin
      used = map_word | ~valid_mask;
      for (int j = 0; j < NB; j++) begin
         last_used[0][j] = used[j] ? (LV+1)'(j + 1) : '0;
      end
      for (int l = 0; l < LV; l++) begin
         for (int j = 0; j < NB; j++) begin
            if (j >= (1 << l) && last_used[l][j - (1 << l)] > last_used[l][j]) begin
               last_used[l+1][j] = last_used[l][j - (1 << l)];
            end else begin
               last_used[l+1][j] = last_used[l][j];
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < NB; j++) begin
         if (last_used[LV][j] == '0) begin
            run_end[j] = {1'b0, run_in} + bpra_pkg::RUN_W'(j + 1);
         end else begin
            run_end[j] = bpra_pkg::RUN_W'(j + 1) - bpra_pkg::RUN_W'(last_used[LV][j]);
         end
         hit_vec[j] = (run_end[j] >= {1'b0, count});
      end
   end

   // lowest hit position
   always_comb begin
      result.hit     = |hit_vec;
      result.pos     = '0;
      result.run_out = run_end[NB-1][bpra_pkg::CNT_W-1:0];
      for (int j = NB - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            result.pos = LV'(j);
         end
      end
   end

endmodule

// ----- tb/bitmap_page_run_allocator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator_unit_tb: self-checking bench for the page allocator
// A page map model predicts status and run address for every accepted
// request. Directed corner items run first, then random alloc/free traffic
// over a series of pool base and size settings.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator_unit_tb;
   import bpra_pkg::*;

   localparam int NUM_PAGES    = NUM_PAGES_DEF;
   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 5;
   localparam int TAIL_CYCLES  = 40;
   localparam int NUM_PHASES   = 9;
   localparam int DRAIN_EVERY  = 100;
   localparam int TIMEOUT_NS   = 40_000_000;
   localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;

   // -------------------------------------------------------------------------
   // Page map model: own copy of the map and registers, plus the queue of
   // results still owed by the block.
   // -------------------------------------------------------------------------
   class page_map_scoreboard;
      logic [NUM_PAGES-1:0] used_pages;
      logic [ADDR_W-1:0]    pool_base;
      logic [CNT_W-1:0]     pool_reg;
      rsp_type              owed_q[$];
      int unsigned          mismatches;

      function new();
         used_pages = '0;
         pool_base  = BASE_RESET;
         pool_reg   = POOL_PAGES_RESET;
         mismatches = 0;
      endfunction

      // register may exceed the map size; the map size then wins
      function int unsigned pool_pages_in_effect();
         return (pool_reg > NUM_PAGES) ? NUM_PAGES : pool_reg;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [ADDR_W-1:0] data);
         if (index == CSR_BASE) begin
            pool_base = data;
         end else if (index == CSR_POOL) begin
            pool_reg = data[CNT_W-1:0];
         end
      endfunction

      function rsp_type note_request(req_type req);
         int unsigned       pool;
         int unsigned       count;
         int unsigned       idx;
         int unsigned       run;
         int unsigned       first;
         bit                found;
         logic [ADDR_W-1:0] offset;
         rsp_type           res;
         pool            = pool_pages_in_effect();
         count           = req.page_count;
         res.status      = ST_DONE;
         res.run_address = '0;
         found           = 1'b0;
         run             = 0;
         first           = 0;
         if (count == 0 || count > pool) begin
            res.status = ST_BAD;
         end else if (req.mode == MODE_ALLOC) begin
            // first fit: lowest run of count free pages
            for (int i = 0; i < pool && !found; i++) begin
               if (used_pages[i]) begin
                  run = 0;
               end else begin
                  if (run == 0) first = i;
                  run++;
                  if (run == count) found = 1'b1;
               end
            end
            if (found) begin
               for (int i = first; i < first + count; i++) used_pages[i] = 1'b1;
               res.run_address = pool_base + ADDR_W'(first << PAGE_SHIFT);
            end else begin
               res.status = ST_NOSPACE;
            end
         end else begin
            // addresses below base wrap to huge offsets and fail the range test
            offset = req.address - pool_base;
            idx    = offset >> PAGE_SHIFT;
            if (offset[PAGE_SHIFT-1:0] != '0 || idx >= pool || count > pool - idx) begin
               res.status = ST_BAD;
            end else begin
               for (int i = idx; i < idx + count; i++) used_pages[i] = 1'b0;
            end
         end
         owed_q.push_back(res);
         return res;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            $error("unexpected result: status %0d run_address %h", got.status, got.run_address);
            mismatches++;
            return;
         end
         want = owed_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.run_address !== want.run_address) begin
            $error("run_address: expected %h, actual %h", want.run_address, got.run_address);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction
   endclass

   // runs handed out by the block, kept to build realistic frees
   typedef struct {
      int unsigned first;
      int unsigned pages;
   } page_run_type;

   typedef struct {
      logic [ADDR_W-1:0] base_value;
      logic [CNT_W-1:0]  pool_value;
      int unsigned       item_total;
   } phase_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_item  = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [ADDR_W-1:0]     csr_data  = '0;

   page_map_scoreboard    sb = new();
   page_run_type          live_runs[$];
   phase_type             plan[NUM_PHASES];

   bitmap_page_run_allocator_unit #(
      .NUM_PAGES (NUM_PAGES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Results cannot be held off: take each strobe as it comes. Values read
   // here are the ones the edge sampled, since the block updates them by NBA.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_result(rsp_item);
   end

   // hard stop in case the block hangs
   initial begin
      #TIMEOUT_NS;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic req_type request_of(logic mode, int unsigned count,
                                          logic [ADDR_W-1:0] addr);
      req_type req;
      req.mode       = mode;
      req.page_count = count[CNT_W-1:0];
      req.address    = addr;
      return req;
   endfunction

   // Start stays high from one item to the next; only pauses and drains lower it.
   // Accepted at the edge where start is high and busy was low.
   task automatic send_request(req_type req);
      rsp_type predicted;
      start    <= 1'b1;
      req_item <= req;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = sb.note_request(req);
      if (req.mode == MODE_ALLOC && predicted.status == ST_DONE) begin
         live_runs.push_back('{(predicted.run_address - sb.pool_base) >> PAGE_SHIFT,
                               req.page_count});
      end
   endtask

   task automatic pause_requests(int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every owed result is back and the block is idle
   task automatic drain_results();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Both registers per phase; valid stays high across the two writes.
   // Upper data bits of the pool write are junk the block must drop.
   task automatic program_pool(logic [ADDR_W-1:0] base_val, logic [CNT_W-1:0] pool_val);
      logic [ADDR_W-1:0] pool_data;
      pool_data              = $urandom();
      pool_data[CNT_W-1:0]   = pool_val;
      csr_valid <= 1'b1;
      csr_index <= CSR_BASE;
      csr_data  <= base_val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_register(CSR_BASE, base_val);
      csr_index <= CSR_POOL;
      csr_data  <= pool_data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_register(CSR_POOL, pool_data);
      csr_valid <= 1'b0;
   endtask

   // mostly small runs, now and then anything the field holds
   function automatic logic [CNT_W-1:0] random_count(int unsigned pool);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 8);
      if (roll < 90) return $urandom_range(1, 64);
      if (roll < 97 && pool > 0) return $urandom_range(1, pool);
      return $urandom_range(0, CNT_MAX);
   endfunction

   // Traffic mix: allocs, frees of live runs (whole or tail), aligned frees
   // anywhere around the pool, garbage frees and zero counts.
   function automatic req_type random_request();
      req_type      req;
      int unsigned  pool;
      int unsigned  roll;
      int unsigned  pick;
      int unsigned  part;
      page_run_type victim;
      pool           = sb.pool_pages_in_effect();
      roll           = $urandom_range(0, 99);
      req.mode       = MODE_ALLOC;
      req.page_count = random_count(pool);
      req.address    = $urandom();     // ignored on alloc
      if (roll >= 45 && roll < 85 && live_runs.size() > 0) begin
         pick     = $urandom_range(0, live_runs.size() - 1);
         victim   = live_runs[pick];
         req.mode = MODE_FREE;
         if ($urandom_range(0, 3) == 0 && victim.pages > 1) begin
            // give back the tail, head stays allocated
            part           = $urandom_range(1, victim.pages - 1);
            req.address    = sb.pool_base + ((victim.first + part) << PAGE_SHIFT);
            req.page_count = victim.pages - part;
            live_runs[pick].pages = part;
         end else begin
            req.address    = sb.pool_base + (victim.first << PAGE_SHIFT);
            req.page_count = victim.pages;
            live_runs.delete(pick);
         end
      end else if (roll >= 85 && roll < 92) begin
         // double frees, overruns past the pool end
         req.mode    = MODE_FREE;
         req.address = sb.pool_base + ($urandom_range(0, pool + 2) << PAGE_SHIFT);
      end else if (roll >= 92 && roll < 97) begin
         req.mode       = MODE_FREE;
         req.page_count = $urandom_range(0, CNT_MAX);
      end else if (roll >= 97) begin
         req.mode       = $urandom_range(0, 1);
         req.page_count = '0;
      end
      return req;
   endfunction

   initial begin
      int unsigned pool;
      bit          gaps_on;
      bit          last_phase;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed corners, reset register values (base 0, 4096 pages) ----
      // map clear pass after reset is covered by the busy handshake
      send_request(request_of(MODE_ALLOC, 0, '0));                   // zero count
      send_request(request_of(MODE_FREE, 0, '0));
      send_request(request_of(MODE_ALLOC, NUM_PAGES + 1, '0));       // larger than pool
      send_request(request_of(MODE_ALLOC, CNT_MAX, '1));
      send_request(request_of(MODE_ALLOC, 1, '1));                   // page 0
      send_request(request_of(MODE_ALLOC, 3, '0));                   // pages 1..3
      send_request(request_of(MODE_FREE, 1, '0));                    // hole at page 0
      send_request(request_of(MODE_ALLOC, 2, '0));                   // must skip the hole
      send_request(request_of(MODE_ALLOC, 1, '0));                   // fills the hole
      send_request(request_of(MODE_FREE, 1, 32'h0000_1004));         // misaligned
      send_request(request_of(MODE_FREE, 1, NUM_PAGES * PAGE_BYTES)); // past pool end
      send_request(request_of(MODE_FREE, 10, (NUM_PAGES - 6) * PAGE_BYTES)); // overrun
      send_request(request_of(MODE_FREE, 1, (NUM_PAGES - 1) * PAGE_BYTES));  // already free
      send_request(request_of(MODE_FREE, 1, 32'hFFFF_F000));         // wraps to huge index
      send_request(request_of(MODE_FREE, NUM_PAGES, '0));            // clear all
      send_request(request_of(MODE_ALLOC, NUM_PAGES, '0));           // whole pool
      send_request(request_of(MODE_ALLOC, 1, '0));                   // no space
      send_request(request_of(MODE_FREE, 50, 100 * PAGE_BYTES));
      send_request(request_of(MODE_ALLOC, 51, '0));                  // hole one short
      send_request(request_of(MODE_ALLOC, 50, '0));                  // exact fit
      send_request(request_of(MODE_FREE, NUM_PAGES + 1, '0));        // free too large
      send_request(request_of(MODE_FREE, NUM_PAGES, '0));
      drain_results();
      live_runs.delete();

      // ---- random traffic over several pool settings ----
      plan[0] = '{32'h0000_0000, CNT_W'(NUM_PAGES), 150};
      plan[1] = '{32'hFFFF_8000, 13'd40, 150};              // run addresses wrap at page 8
      plan[2] = '{$urandom() & 32'hFFFF_F000, 13'd1, 40};   // single page pool
      plan[3] = '{$urandom(), 13'd0, 30};                   // empty pool, all flagged
      plan[4] = '{32'h1234_5678, 13'd100, 150};             // base not page aligned
      plan[5] = '{32'hFFFF_FFFF, 13'd16, 100};
      plan[6] = '{$urandom() & 32'hFFFF_F000, CNT_W'(CNT_MAX), 120}; // clipped to map
      plan[7] = '{$urandom() & 32'hFFFF_F000, CNT_W'($urandom_range(2, 300)), 150};
      plan[8] = '{32'hFFFF_F000, CNT_W'(NUM_PAGES), 120};   // all but page 0 wrap

      for (int p = 0; p < NUM_PHASES; p++) begin
         last_phase = (p == NUM_PHASES - 1);
         program_pool(plan[p].base_value, plan[p].pool_value);
         pool = sb.pool_pages_in_effect();
         // sometimes start from an empty map, sometimes keep the old pages
         if (pool > 0 && $urandom_range(0, 1) == 1) begin
            send_request(request_of(MODE_FREE, pool, sb.pool_base));
            live_runs.delete();
         end
         gaps_on = 1'b1;
         for (int n = 0; n < plan[p].item_total; n++) begin
            if (n % 25 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
               drain_results();
            end else if (!last_phase && gaps_on && $urandom_range(0, 3) == 0) begin
               pause_requests($urandom_range(1, 15));
            end
            send_request(random_request());
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- bitmap_page_run_allocator_unit.f -----
design/bpra_pkg.sv
design/bpra_map_ram.sv
design/bpra_word_scan.sv
design/bitmap_page_run_allocator_unit.sv
tb/bitmap_page_run_allocator_unit_tb.sv
